@@ design/assert_macros.svh @@
// assertion macros used by the token update design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, cond, conseq) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, cond, conseq) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("assertion failed");

`endif

@@ design/lcu_pkg.sv @@
// types, constants and helper functions of the cvb0 token update block
package lcu_pkg;

   localparam int TOPICS        = 16;
   localparam int VOCAB_SIZE    = 4096;
   localparam int DOC_COUNT     = 1024;
   localparam int TOKEN_COUNT   = 16384;
   localparam int FRACTION_BITS = 16;

   localparam int TW  = $clog2(TOPICS);
   localparam int WAW = $clog2(VOCAB_SIZE * TOPICS);
   localparam int DAW = $clog2(DOC_COUNT * TOPICS);
   localparam int TAW = $clog2(TOKEN_COUNT * 3);

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [16:0] Q_ONE = 17'h1_0000;

   localparam logic [1:0] CMD_PROCESS = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [2:0] SEL_WORD_CNT   = 3'd0;
   localparam logic [2:0] SEL_DOC_CNT    = 3'd1;
   localparam logic [2:0] SEL_TOPIC_CNT  = 3'd2;
   localparam logic [2:0] SEL_WORD_PRIOR = 3'd3;
   localparam logic [2:0] SEL_DOC_PRIOR  = 3'd4;
   localparam logic [2:0] SEL_TOPIC_PRIOR = 3'd5;
   localparam logic [2:0] SEL_TOKEN_Q    = 3'd6;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  table_select;
      logic [13:0] row_index;
      logic [3:0]  column_index;
      logic [31:0] write_value;
      logic [13:0] token_index;
      logic [11:0] word_id;
      logic [9:0]  doc_id;
      logic [3:0]  third_topic;
   } req_type;

   typedef struct packed {
      logic [16:0] q_topic_zero;
      logic [16:0] q_topic_one;
      logic [16:0] q_topic_third;
      logic [31:0] read_value;
      logic        status;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? MAX32 : s[31:0];
   endfunction

   function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
      return (a > b) ? (a - b) : 32'd0;
   endfunction

   // responsibility scaled into count units
   function automatic logic [31:0] q_to_count(input logic [16:0] q);
      localparam int UP   = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
      localparam int DOWN = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
      logic [63:0] v;
      v = (64'(q) << UP) >> DOWN;
      return v[31:0];
   endfunction

endpackage

@@ design/lcu_req_if.sv @@
// request channel interface
interface lcu_req_if;
   import lcu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

@@ design/lcu_rsp_if.sv @@
// response channel interface
interface lcu_rsp_if;
   import lcu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

@@ design/lda_cvb0_token_update.sv @@
// table write or read passes access, capture and finish states; a rejected command goes
// straight to finish; token process reads three slots and subtracts, then one bit-serial
// 64-step divider serves three quotients (skipped for a zero divisor) and three normalizing
// divisions before slot writes and adds; one transaction at a time, the next may be accepted
// while a finished response waits, and finishing stalls while the previous response is held
// reset clears the sequencer and response valid; table contents are undefined until written
module lda_cvb0_token_update (
   input logic clock,
   input logic reset,
   lcu_req_if.sink   req_chan,
   lcu_rsp_if.source rsp_chan
);
   import lcu_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [4:0] {
      ST_IDLE, ST_TBL_ACC, ST_TBL_CAP, ST_SLOT_RD, ST_SLOT_CAP, ST_DEC_RD, ST_DEC_WR,
      ST_Q_RD, ST_Q_SUM, ST_Q_MUL, ST_DIV_RUN, ST_Q_END, ST_N_START, ST_N_END,
      ST_SLOT_WR, ST_INC_RD, ST_INC_WR, ST_FINISH
   } state_type;

   state_type   state_ff;
   logic [1:0]  j_ff;
   logic [1:0]  cmd_ff;
   logic [2:0]  sel_ff;
   logic [13:0] row_ff;
   logic [3:0]  col_ff;
   logic [31:0] val_ff;
   logic [13:0] t_ff;
   logic [11:0] w_ff;
   logic [9:0]  d_ff;
   logic [3:0]  k3_ff;
   logic        bad_ff;
   logic [16:0] qold_ff [3];
   logic [16:0] qnew_ff [3];
   logic [31:0] p_ff [3];
   logic [31:0] dd_ff, aa_ff, bb_ff;
   logic [31:0] rdval_ff;
   logic [63:0] dvd_ff;
   logic [33:0] dvs_ff;
   logic [34:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        norm_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // table memories
   logic [31:0] wc_mem [VOCAB_SIZE * TOPICS];
   logic [31:0] wp_mem [VOCAB_SIZE * TOPICS];
   logic [31:0] dc_mem [DOC_COUNT * TOPICS];
   logic [31:0] dp_mem [DOC_COUNT * TOPICS];
   logic [31:0] tt_mem [TOPICS];
   logic [31:0] tp_mem [TOPICS];
   logic [16:0] tq_mem [TOKEN_COUNT * 3];
   logic [31:0] wc_rd, wp_rd, dc_rd, dp_rd, tt_rd, tp_rd;
   logic [16:0] tq_rd;

   logic [TW-1:0]  cur_topic, topic_addr;
   logic [WAW-1:0] word_addr;
   logic [DAW-1:0] doc_addr;
   logic [TAW-1:0] tok_addr;
   logic           is_proc, tbl_wr, rmw_wr;
   logic [16:0]    qold_eff, delta_q;
   logic [31:0]    delta;
   logic           wc_we, wp_we, dc_we, dp_we, tt_we, tp_we, tq_we;
   logic [31:0]    wc_wd, dc_wd, tt_wd;
   logic [16:0]    tq_wd;
   logic           req_bad;
   logic [33:0]    psum;
   logic [34:0]    rem_shift, rem_next;
   logic           div_ge;
   req_type        rq;

   assign rq = req_chan.data;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      priority case (rq.table_select)
         SEL_WORD_CNT, SEL_WORD_PRIOR:
            req_bad = (32'(rq.row_index) >= 32'(VOCAB_SIZE))
                   || (32'(rq.column_index) >= 32'(TOPICS));
         SEL_DOC_CNT, SEL_DOC_PRIOR:
            req_bad = (32'(rq.row_index) >= 32'(DOC_COUNT))
                   || (32'(rq.column_index) >= 32'(TOPICS));
         SEL_TOPIC_CNT, SEL_TOPIC_PRIOR:
            req_bad = (32'(rq.column_index) >= 32'(TOPICS));
         SEL_TOKEN_Q:
            req_bad = (32'(rq.row_index) >= 32'(TOKEN_COUNT)) || (rq.column_index >= 4'd3);
         default: req_bad = 1'b1;
      endcase
      if (rq.cmd == CMD_PROCESS) begin
         req_bad = (32'(rq.token_index) >= 32'(TOKEN_COUNT))
                || (32'(rq.word_id) >= 32'(VOCAB_SIZE))
                || (32'(rq.doc_id) >= 32'(DOC_COUNT))
                || (32'(rq.third_topic) >= 32'(TOPICS));
      end else if (rq.cmd != CMD_WRITE && rq.cmd != CMD_READ) begin
         req_bad = 1'b1;
      end
   end

   // addresses for table commands or for the token being processed
   always_comb begin
      is_proc = (cmd_ff == CMD_PROCESS);
      priority case (j_ff)
         2'd0:    cur_topic = '0;
         2'd1:    cur_topic = TW'(1);
         default: cur_topic = TW'(k3_ff);
      endcase
      if (is_proc) begin
         topic_addr = cur_topic;
         word_addr  = WAW'(w_ff) * WAW'(TOPICS) + WAW'(cur_topic);
         doc_addr   = DAW'(d_ff) * DAW'(TOPICS) + DAW'(cur_topic);
         tok_addr   = TAW'(t_ff) * TAW'(3) + TAW'(j_ff);
      end else begin
         topic_addr = TW'(col_ff);
         word_addr  = WAW'(row_ff) * WAW'(TOPICS) + WAW'(col_ff);
         doc_addr   = DAW'(row_ff) * DAW'(TOPICS) + DAW'(col_ff);
         tok_addr   = TAW'(row_ff) * TAW'(3) + TAW'(col_ff);
      end
   end

   // third slot falls back to slot 0 or 1 when the third topic repeats one
   always_comb begin
      if (j_ff == 2'd2 && k3_ff < 4'd2) begin
         qold_eff = qold_ff[k3_ff[0]];
      end else begin
         qold_eff = qold_ff[j_ff];
      end
      delta_q = (state_ff == ST_INC_WR) ? qnew_ff[j_ff] : qold_eff;
      delta   = q_to_count(delta_q);
      tbl_wr  = (state_ff == ST_TBL_ACC) && (cmd_ff == CMD_WRITE);
      rmw_wr  = (state_ff == ST_DEC_WR) || (state_ff == ST_INC_WR);
      wc_we = rmw_wr || (tbl_wr && sel_ff == SEL_WORD_CNT);
      dc_we = rmw_wr || (tbl_wr && sel_ff == SEL_DOC_CNT);
      tt_we = rmw_wr || (tbl_wr && sel_ff == SEL_TOPIC_CNT);
      wp_we = tbl_wr && sel_ff == SEL_WORD_PRIOR;
      dp_we = tbl_wr && sel_ff == SEL_DOC_PRIOR;
      tp_we = tbl_wr && sel_ff == SEL_TOPIC_PRIOR;
      tq_we = (state_ff == ST_SLOT_WR) || (tbl_wr && sel_ff == SEL_TOKEN_Q);
      if (tbl_wr) begin
         wc_wd = val_ff;
         dc_wd = val_ff;
         tt_wd = val_ff;
         tq_wd = (val_ff > 32'(Q_ONE)) ? Q_ONE : val_ff[16:0];
      end else if (state_ff == ST_INC_WR) begin
         wc_wd = sat_add(wc_rd, delta);
         dc_wd = sat_add(dc_rd, delta);
         tt_wd = sat_add(tt_rd, delta);
         tq_wd = qnew_ff[j_ff];
      end else begin
         wc_wd = sat_sub(wc_rd, delta);
         dc_wd = sat_sub(dc_rd, delta);
         tt_wd = sat_sub(tt_rd, delta);
         tq_wd = qnew_ff[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wc_we) wc_mem[word_addr] <= wc_wd;
      wc_rd <= wc_mem[word_addr];
   end
   always_ff @(posedge clock) begin
      if (wp_we) wp_mem[word_addr] <= val_ff;
      wp_rd <= wp_mem[word_addr];
   end
   always_ff @(posedge clock) begin
      if (dc_we) dc_mem[doc_addr] <= dc_wd;
      dc_rd <= dc_mem[doc_addr];
   end
   always_ff @(posedge clock) begin
      if (dp_we) dp_mem[doc_addr] <= val_ff;
      dp_rd <= dp_mem[doc_addr];
   end
   always_ff @(posedge clock) begin
      if (tt_we) tt_mem[topic_addr] <= tt_wd;
      tt_rd <= tt_mem[topic_addr];
   end
   always_ff @(posedge clock) begin
      if (tp_we) tp_mem[topic_addr] <= val_ff;
      tp_rd <= tp_mem[topic_addr];
   end
   always_ff @(posedge clock) begin
      if (tq_we) tq_mem[tok_addr] <= tq_wd;
      tq_rd <= tq_mem[tok_addr];
   end

   // shared restoring divider, one quotient bit per cycle
   always_comb begin
      psum      = 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]);
      rem_shift = {rem_ff[33:0], dvd_ff[63]};
      div_ge    = (rem_shift >= {1'b0, dvs_ff});
      rem_next  = div_ge ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         j_ff         <= 2'd0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff <= rq.cmd;
                  sel_ff <= rq.table_select;
                  row_ff <= rq.row_index;
                  col_ff <= rq.column_index;
                  val_ff <= rq.write_value;
                  t_ff   <= rq.token_index;
                  w_ff   <= rq.word_id;
                  d_ff   <= rq.doc_id;
                  k3_ff  <= rq.third_topic;
                  bad_ff <= req_bad;
                  j_ff   <= 2'd0;
                  if (req_bad) begin
                     state_ff <= ST_FINISH;
                  end else if (rq.cmd == CMD_PROCESS) begin
                     state_ff <= ST_SLOT_RD;
                  end else begin
                     state_ff <= ST_TBL_ACC;
                  end
               end
            end
            ST_TBL_ACC: state_ff <= ST_TBL_CAP;
            ST_TBL_CAP: begin
               unique case (sel_ff)
                  SEL_WORD_CNT:    rdval_ff <= wc_rd;
                  SEL_DOC_CNT:     rdval_ff <= dc_rd;
                  SEL_TOPIC_CNT:   rdval_ff <= tt_rd;
                  SEL_WORD_PRIOR:  rdval_ff <= wp_rd;
                  SEL_DOC_PRIOR:   rdval_ff <= dp_rd;
                  SEL_TOPIC_PRIOR: rdval_ff <= tp_rd;
                  default:         rdval_ff <= 32'(tq_rd);
               endcase
               state_ff <= ST_FINISH;
            end
            ST_SLOT_RD: state_ff <= ST_SLOT_CAP;
            ST_SLOT_CAP: begin
               qold_ff[j_ff] <= tq_rd;
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_DEC_RD;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_SLOT_RD;
               end
            end
            ST_DEC_RD: state_ff <= ST_DEC_WR;
            ST_DEC_WR: begin
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_Q_RD;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_DEC_RD;
               end
            end
            ST_Q_RD: state_ff <= ST_Q_SUM;
            ST_Q_SUM: begin
               dd_ff    <= sat_add(dp_rd, dc_rd);
               aa_ff    <= sat_add(wp_rd, wc_rd);
               bb_ff    <= sat_add(tp_rd, tt_rd);
               state_ff <= ST_Q_MUL;
            end
            ST_Q_MUL: begin
               if (bb_ff == 32'd0) begin
                  p_ff[j_ff] <= MAX32;
                  if (j_ff == 2'd2) begin
                     j_ff     <= 2'd0;
                     state_ff <= ST_N_START;
                  end else begin
                     j_ff     <= j_ff + 2'd1;
                     state_ff <= ST_Q_RD;
                  end
               end else begin
                  dvd_ff   <= dd_ff * aa_ff;
                  dvs_ff   <= {2'b00, bb_ff};
                  rem_ff   <= '0;
                  cnt_ff   <= '1;
                  norm_ff  <= 1'b0;
                  state_ff <= ST_DIV_RUN;
               end
            end
            ST_DIV_RUN: begin
               rem_ff <= rem_next;
               dvd_ff <= {dvd_ff[62:0], div_ge};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  state_ff <= norm_ff ? ST_N_END : ST_Q_END;
               end
            end
            ST_Q_END: begin
               if (|dvd_ff[63:32]) begin
                  p_ff[j_ff] <= MAX32;
               end else if (dvd_ff[31:0] == 32'd0) begin
                  p_ff[j_ff] <= 32'd1;
               end else begin
                  p_ff[j_ff] <= dvd_ff[31:0];
               end
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_N_START;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_Q_RD;
               end
            end
            ST_N_START: begin
               dvd_ff   <= 64'(p_ff[j_ff]) << 16;
               dvs_ff   <= psum;
               rem_ff   <= '0;
               cnt_ff   <= '1;
               norm_ff  <= 1'b1;
               state_ff <= ST_DIV_RUN;
            end
            ST_N_END: begin
               qnew_ff[j_ff] <= dvd_ff[16:0];
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_SLOT_WR;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_N_START;
               end
            end
            ST_SLOT_WR: begin
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_INC_RD;
               end else begin
                  j_ff <= j_ff + 2'd1;
               end
            end
            ST_INC_RD: state_ff <= ST_INC_WR;
            ST_INC_WR: begin
               if (j_ff == 2'd2) begin
                  j_ff     <= 2'd0;
                  state_ff <= ST_FINISH;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_INC_RD;
               end
            end
            ST_FINISH: begin
               // hold until the previous response has left
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff               <= 1'b1;
                  rsp_data_ff.status         <= bad_ff;
                  rsp_data_ff.read_value     <= (!bad_ff && cmd_ff == CMD_READ) ?
                                                rdval_ff : 32'd0;
                  rsp_data_ff.q_topic_zero   <= (!bad_ff && is_proc) ? qnew_ff[0] : 17'd0;
                  rsp_data_ff.q_topic_one    <= (!bad_ff && is_proc) ? qnew_ff[1] : 17'd0;
                  rsp_data_ff.q_topic_third  <= (!bad_ff && is_proc) ? qnew_ff[2] : 17'd0;
                  state_ff                   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ASSERT_SAME(a_error_clears_fields, rsp_valid_ff && rsp_data_ff.status, rsp_data_ff.q_topic_zero == 17'd0 && rsp_data_ff.q_topic_third == 17'd0 && rsp_data_ff.read_value == 32'd0)
   `ASSERT_SAME(a_q_bounded, rsp_valid_ff, rsp_data_ff.q_topic_zero <= Q_ONE && rsp_data_ff.q_topic_one <= Q_ONE && rsp_data_ff.q_topic_third <= Q_ONE)

endmodule

@@ tb/tb_lda_cvb0_token_update.sv @@
// testbench for the cvb0 token update block: shadow tables, scoreboard and random traffic
`timescale 1ns / 1ps

module tb_lda_cvb0_token_update;
   import lcu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_TARGET    = 1150;
   localparam int DRAIN_CYCLES   = 500;

   // shadow copy of the block's tables and the expected responses
   class token_scoreboard;
      bit [31:0] word_cnt[int];
      bit [31:0] doc_cnt[int];
      bit [31:0] topic_cnt[int];
      bit [31:0] word_prior[int];
      bit [31:0] doc_prior[int];
      bit [31:0] topic_prior[int];
      bit [16:0] token_q[int];
      rsp_type   expected_rsp[$];
      int        errors;

      function bit locate(input bit [2:0] sel, input int row, input int col, output int key);
         key = 0;
         case (sel)
            SEL_WORD_CNT, SEL_WORD_PRIOR: begin
               key = row * TOPICS + col;
               return row < VOCAB_SIZE && col < TOPICS;
            end
            SEL_DOC_CNT, SEL_DOC_PRIOR: begin
               key = row * TOPICS + col;
               return row < DOC_COUNT && col < TOPICS;
            end
            SEL_TOPIC_CNT, SEL_TOPIC_PRIOR: begin
               key = col;
               return col < TOPICS;
            end
            SEL_TOKEN_Q: begin
               key = row * 3 + col;
               return row < TOKEN_COUNT && col < 3;
            end
            default: return 0;
         endcase
      endfunction

      function bit has_entry(input bit [2:0] sel, input int key);
         case (sel)
            SEL_WORD_CNT:    return word_cnt.exists(key);
            SEL_DOC_CNT:     return doc_cnt.exists(key);
            SEL_TOPIC_CNT:   return topic_cnt.exists(key);
            SEL_WORD_PRIOR:  return word_prior.exists(key);
            SEL_DOC_PRIOR:   return doc_prior.exists(key);
            SEL_TOPIC_PRIOR: return topic_prior.exists(key);
            SEL_TOKEN_Q:     return token_q.exists(key);
            default:         return 0;
         endcase
      endfunction

      function bit [31:0] sat_sum(input bit [63:0] v);
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      function bit [31:0] q_units(input bit [16:0] q);
         bit [63:0] v;
         v = {47'b0, q};
         if (FRACTION_BITS >= 16) v = v << (FRACTION_BITS - 16);
         else v = v >> (16 - FRACTION_BITS);
         return v[31:0];
      endfunction

      function void move_counts(input int w, input int d, input int k, input bit [31:0] delta,
                                input bit add);
         int wk;
         int dk;
         wk = w * TOPICS + k;
         dk = d * TOPICS + k;
         if (add) begin
            topic_cnt[k] = sat_sum(64'(topic_cnt[k]) + delta);
            word_cnt[wk] = sat_sum(64'(word_cnt[wk]) + delta);
            doc_cnt[dk]  = sat_sum(64'(doc_cnt[dk]) + delta);
         end else begin
            topic_cnt[k] = (topic_cnt[k] > delta) ? topic_cnt[k] - delta : 32'd0;
            word_cnt[wk] = (word_cnt[wk] > delta) ? word_cnt[wk] - delta : 32'd0;
            doc_cnt[dk]  = (doc_cnt[dk] > delta) ? doc_cnt[dk] - delta : 32'd0;
         end
      endfunction

      function bit [31:0] topic_weight(input int w, input int d, input int k);
         bit [63:0] dd;
         bit [63:0] aa;
         bit [63:0] bb;
         bit [31:0] p;
         dd = sat_sum(64'(doc_prior[d * TOPICS + k]) + doc_cnt[d * TOPICS + k]);
         aa = sat_sum(64'(word_prior[w * TOPICS + k]) + word_cnt[w * TOPICS + k]);
         bb = sat_sum(64'(topic_prior[k]) + topic_cnt[k]);
         if (bb == 0) return 32'hFFFF_FFFF;
         p = sat_sum((dd * aa) / bb);
         return (p == 0) ? 32'd1 : p;
      endfunction

      function rsp_type predict_token(input req_type r);
         rsp_type   e;
         int        key;
         int        t;
         int        w;
         int        d;
         int        topic[3];
         bit [16:0] q_old[3];
         bit [16:0] q_new[3];
         bit [31:0] p[3];
         bit [63:0] total;
         e = '0;
         if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
            if (!locate(r.table_select, int'(r.row_index), int'(r.column_index), key)) begin
               e.status = 1'b1;
            end else if (r.cmd == CMD_WRITE) begin
               case (r.table_select)
                  SEL_WORD_CNT:    word_cnt[key] = r.write_value;
                  SEL_DOC_CNT:     doc_cnt[key] = r.write_value;
                  SEL_TOPIC_CNT:   topic_cnt[key] = r.write_value;
                  SEL_WORD_PRIOR:  word_prior[key] = r.write_value;
                  SEL_DOC_PRIOR:   doc_prior[key] = r.write_value;
                  SEL_TOPIC_PRIOR: topic_prior[key] = r.write_value;
                  default: token_q[key] = (r.write_value > 32'h1_0000) ? 17'h1_0000
                                                                      : r.write_value[16:0];
               endcase
            end else begin
               case (r.table_select)
                  SEL_WORD_CNT:    e.read_value = word_cnt[key];
                  SEL_DOC_CNT:     e.read_value = doc_cnt[key];
                  SEL_TOPIC_CNT:   e.read_value = topic_cnt[key];
                  SEL_WORD_PRIOR:  e.read_value = word_prior[key];
                  SEL_DOC_PRIOR:   e.read_value = doc_prior[key];
                  SEL_TOPIC_PRIOR: e.read_value = topic_prior[key];
                  default:         e.read_value = 32'(token_q[key]);
               endcase
            end
            return e;
         end
         if (r.cmd != CMD_PROCESS || r.token_index >= TOKEN_COUNT || r.word_id >= VOCAB_SIZE ||
             r.doc_id >= DOC_COUNT || r.third_topic >= TOPICS) begin
            e.status = 1'b1;
            return e;
         end
         t = int'(r.token_index);
         w = int'(r.word_id);
         d = int'(r.doc_id);
         topic[0] = 0;
         topic[1] = 1;
         topic[2] = int'(r.third_topic);
         q_old[0] = token_q[t * 3];
         q_old[1] = token_q[t * 3 + 1];
         // a third topic of 0 or 1 reuses that topic's slot
         q_old[2] = (topic[2] < 2) ? token_q[t * 3 + topic[2]] : token_q[t * 3 + 2];
         for (int j = 0; j < 3; j++) move_counts(w, d, topic[j], q_units(q_old[j]), 1'b0);
         total = 0;
         for (int j = 0; j < 3; j++) begin
            p[j] = topic_weight(w, d, topic[j]);
            total += 64'(p[j]);
         end
         for (int j = 0; j < 3; j++) q_new[j] = 17'((64'(p[j]) << 16) / total);
         for (int j = 0; j < 3; j++) token_q[t * 3 + j] = q_new[j];
         for (int j = 0; j < 3; j++) move_counts(w, d, topic[j], q_units(q_new[j]), 1'b1);
         e.q_topic_zero  = q_new[0];
         e.q_topic_one   = q_new[1];
         e.q_topic_third = q_new[2];
         return e;
      endfunction

      function void note_request(input req_type r);
         expected_rsp.push_back(predict_token(r));
      endfunction

      function void check_response(input rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", a);
            return;
         end
         e = expected_rsp.pop_front();
         if (a.q_topic_zero !== e.q_topic_zero || a.q_topic_one !== e.q_topic_one ||
             a.q_topic_third !== e.q_topic_third || a.read_value !== e.read_value ||
             a.status !== e.status) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lcu_req_if req_chan();
   lcu_rsp_if rsp_chan();

   lda_cvb0_token_update dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   token_scoreboard sb;
   bit quiet;
   int rsp_stall;
   int idle_cycles;
   int sent;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // response side: random stalls, ready changes at the falling edge
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_response(rsp_chan.data);
         rsp_stall <= quiet ? 0 : $urandom_range(0, 16);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(input req_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      sent++;
   endtask

   function automatic req_type noise_fields();
      req_type r;
      r = req_type'(95'({$urandom, $urandom, $urandom}));
      return r;
   endfunction

   task automatic table_cmd(input bit [1:0] cmd, input bit [2:0] sel, input int row,
                            input int col, input bit [31:0] value);
      req_type r;
      r = noise_fields();
      r.cmd          = cmd;
      r.table_select = sel;
      r.row_index    = 14'(row);
      r.column_index = 4'(col);
      r.write_value  = value;
      send_req(r);
   endtask

   task automatic process_token(input int t, input int w, input int d, input int k3);
      req_type r;
      r = noise_fields();
      r.cmd         = CMD_PROCESS;
      r.token_index = 14'(t);
      r.word_id     = 12'(w);
      r.doc_id      = 10'(d);
      r.third_topic = 4'(k3);
      send_req(r);
   endtask

   function automatic bit [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(0, 255);
         default: return $urandom_range(1, 40) << 16 | $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic bit [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h1_0000;
         2: return $urandom_range(65537, 70000);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   // writes every entry a token operation will read, either all or only the missing ones
   task automatic load_token(input int t, input int w, input int d, input int k3,
                             input bit only_missing, input bit [31:0] cnt,
                             input bit [31:0] prior, input bit [31:0] tot, input bit [31:0] q);
      int topic[3];
      int rows[6];
      int key;
      bit [31:0] v;
      topic[0] = 0;
      topic[1] = 1;
      topic[2] = k3;
      rows = '{w, d, 0, w, d, 0};
      for (int j = 0; j < 3; j++) begin
         for (int s = 0; s < 6; s++) begin
            void'(sb.locate(3'(s), rows[s], topic[j], key));
            if (!only_missing || !sb.has_entry(3'(s), key)) begin
               if (only_missing) v = rand_value();
               else if (s == SEL_TOPIC_CNT || s == SEL_TOPIC_PRIOR) v = tot;
               else if (s < SEL_WORD_PRIOR) v = cnt;
               else v = prior;
               table_cmd(CMD_WRITE, 3'(s), rows[s], topic[j], v);
            end
         end
      end
      for (int j = 0; j < 3; j++) begin
         if (!only_missing || !sb.has_entry(SEL_TOKEN_Q, t * 3 + j))
            table_cmd(CMD_WRITE, SEL_TOKEN_Q, t, j, only_missing ? rand_q() : q);
      end
   endtask

   function automatic int pick_word();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return VOCAB_SIZE - 1;
         2: return $urandom_range(0, VOCAB_SIZE - 1);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic int pick_doc();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return DOC_COUNT - 1;
         2: return $urandom_range(0, DOC_COUNT - 1);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic int pick_tok();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return TOKEN_COUNT - 1;
         2: return $urandom_range(0, TOKEN_COUNT - 1);
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   initial begin
      int t;
      int w;
      int d;
      int k3;
      int key;
      bit [2:0] sel;
      sb = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      quiet = 1'b0;
      rsp_stall = 0;
      idle_cycles = 0;
      sent = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // saturated sums and a zero divisor on every topic
      load_token(0, 0, 0, 2, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
      process_token(0, 0, 0, 2);
      // tiny quotients, counts driven down to zero
      load_token(TOKEN_COUNT - 1, VOCAB_SIZE - 1, DOC_COUNT - 1, TOPICS - 1, 1'b0,
                 32'd1, 32'd0, 32'hFFFF_FFFF, 32'h1_0000);
      process_token(TOKEN_COUNT - 1, VOCAB_SIZE - 1, DOC_COUNT - 1, TOPICS - 1);
      // third topic repeating topic 0 and topic 1
      process_token(TOKEN_COUNT - 1, VOCAB_SIZE - 1, DOC_COUNT - 1, 0);
      process_token(0, 0, 0, 1);
      // responsibility write saturation, topic tables ignore the row
      table_cmd(CMD_WRITE, SEL_TOKEN_Q, TOKEN_COUNT - 1, 2, 32'hFFFF_FFFF);
      table_cmd(CMD_READ, SEL_TOKEN_Q, TOKEN_COUNT - 1, 2, 32'd0);
      table_cmd(CMD_READ, SEL_TOPIC_CNT, 14'h3FFF, 1, 32'd0);
      table_cmd(CMD_READ, SEL_TOPIC_PRIOR, 12345, 2, 32'd0);
      // out of range and illegal codes
      table_cmd(CMD_WRITE, SEL_WORD_CNT, VOCAB_SIZE + 5, 0, $urandom);
      table_cmd(CMD_READ, SEL_DOC_PRIOR, DOC_COUNT, 3, 32'd0);
      table_cmd(CMD_READ, SEL_TOKEN_Q, 7, 3, 32'd0);
      table_cmd(CMD_WRITE, 3'd7, 0, 0, $urandom);
      table_cmd(2'd3, SEL_WORD_CNT, 0, 0, $urandom);

      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 49) == 0) quiet = !quiet;
         t = pick_tok();
         w = pick_word();
         d = pick_doc();
         k3 = $urandom_range(0, TOPICS - 1);
         sel = 3'($urandom_range(0, 6));
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               load_token(t, w, d, k3, 1'b1, 0, 0, 0, 0);
               process_token(t, w, d, k3);
            end
            7, 8, 9, 10, 11: begin
               if (sel == SEL_TOKEN_Q)
                  table_cmd(CMD_WRITE, sel, t, $urandom_range(0, 2), rand_q());
               else if (sel == SEL_WORD_CNT || sel == SEL_WORD_PRIOR)
                  table_cmd(CMD_WRITE, sel, w, k3, rand_value());
               else
                  table_cmd(CMD_WRITE, sel, d, k3, rand_value());
            end
            12, 13, 14, 15: begin
               if (sel == SEL_TOKEN_Q) void'(sb.locate(sel, t, $urandom_range(0, 2), key));
               else if (sel == SEL_WORD_CNT || sel == SEL_WORD_PRIOR)
                  void'(sb.locate(sel, w, k3, key));
               else void'(sb.locate(sel, d, k3, key));
               if (sb.has_entry(sel, key)) begin
                  if (sel == SEL_TOKEN_Q) table_cmd(CMD_READ, sel, t, key % 3, 0);
                  else if (sel == SEL_WORD_CNT || sel == SEL_WORD_PRIOR)
                     table_cmd(CMD_READ, sel, w, k3, 0);
                  else table_cmd(CMD_READ, sel, d, k3, 0);
               end else begin
                  table_cmd(CMD_READ, SEL_DOC_CNT, $urandom_range(DOC_COUNT, 16383), k3, 0);
               end
            end
            16: table_cmd(CMD_WRITE, SEL_WORD_PRIOR, $urandom_range(VOCAB_SIZE, 16383), k3,
                          $urandom);
            17: table_cmd(2'($urandom_range(1, 2)), SEL_TOKEN_Q, t, $urandom_range(3, 15),
                          $urandom);
            18: table_cmd($urandom_range(0, 3) == 0 ? 2'd3 : CMD_WRITE, 3'd7, t, k3, $urandom);
            default: begin
               // broken request: illegal command code with random operands
               req_type r;
               r = noise_fields();
               r.cmd = 2'd3;
               send_req(r);
            end
         endcase
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.expected_rsp.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ lda_cvb0_token_update.f @@
+incdir+design
design/lcu_pkg.sv
design/lcu_req_if.sv
design/lcu_rsp_if.sv
design/lda_cvb0_token_update.sv
tb/tb_lda_cvb0_token_update.sv
